### rtl/core/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared widths, types and helper functions for the swept box collision time
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sbct_pkg;

    localparam int COORD_BITS      = 16;
    localparam int SHIFT_BITS      = 16;
    localparam int SHIFT_FRAC_BITS = 8;
    localparam int TIME_FRAC_BITS  = 16;

    // Width of an edge-to-edge gap, and of the magnitude of a displacement.
    localparam int GAP_W  = COORD_BITS + 1;
    localparam int DEN_W  = SHIFT_BITS;
    localparam int PROD_W = GAP_W + DEN_W + 1;
    localparam int TIME_W = TIME_FRAC_BITS + 1;
    localparam int DIV_STEPS = TIME_W;

    localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;

    localparam logic [1:0] NORMAL_LEFT  = 2'd0;
    localparam logic [1:0] NORMAL_RIGHT = 2'd1;
    localparam logic [1:0] NORMAL_UP    = 2'd2;
    localparam logic [1:0] NORMAL_DOWN  = 2'd3;

    // A time is a fraction num * 2^SHIFT_FRAC_BITS / den, or an infinity.
    typedef struct packed {
        logic                    pinf;
        logic                    ninf;
        logic signed [GAP_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } span_time_t;

    typedef struct packed {
        span_time_t entry;
        span_time_t leave;
    } axis_times_t;

    // Signed rank of an infinity: -1, 0 for finite, +1.
    function automatic logic signed [1:0] kind_of(input span_time_t t);
        logic signed [1:0] k;
        k = 2'sd0;
        if (t.pinf) begin
            k = 2'sd1;
        end else if (t.ninf) begin
            k = -2'sd1;
        end
        return k;
    endfunction

    // Three-way compare of two times, given the cross products.
    function automatic logic signed [1:0] cmp_time(input span_time_t a,
                                                   input span_time_t b,
                                                   input logic signed [PROD_W-1:0] l,
                                                   input logic signed [PROD_W-1:0] r);
        logic signed [1:0] ka;
        logic signed [1:0] kb;
        logic signed [1:0] c;
        ka = kind_of(a);
        kb = kind_of(b);
        if (ka != 2'sd0 || kb != 2'sd0) begin
            c = (ka == kb) ? 2'sd0 : ((ka < kb) ? -2'sd1 : 2'sd1);
        end else begin
            c = (l < r) ? -2'sd1 : ((l > r) ? 2'sd1 : 2'sd0);
        end
        return c;
    endfunction

    // Cross product num * den of two fractions, both operands widened first.
    function automatic logic signed [PROD_W-1:0] cross_prod(
        input logic signed [GAP_W-1:0] n,
        input logic [DEN_W-1:0] d
    );
        logic signed [PROD_W-1:0] ne;
        logic signed [PROD_W-1:0] de;
        ne = PROD_W'(n);
        de = $signed(PROD_W'(d));
        return ne * de;
    endfunction

    // Entry and exit times along one axis.
    function automatic axis_times_t axis_times(input logic signed [COORD_BITS-1:0] mlo,
                                               input logic signed [COORD_BITS-1:0] mhi,
                                               input logic signed [COORD_BITS-1:0] tlo,
                                               input logic signed [COORD_BITS-1:0] thi,
                                               input logic signed [SHIFT_BITS-1:0] dv);
        axis_times_t res;
        logic        apart;
        logic signed [GAP_W-1:0] mlo_e;
        logic signed [GAP_W-1:0] mhi_e;
        logic signed [GAP_W-1:0] tlo_e;
        logic signed [GAP_W-1:0] thi_e;
        mlo_e = GAP_W'(mlo);
        mhi_e = GAP_W'(mhi);
        tlo_e = GAP_W'(tlo);
        thi_e = GAP_W'(thi);
        apart = (mhi <= tlo) || (mlo >= thi);
        res.entry.pinf = 1'b0;
        res.entry.ninf = 1'b0;
        res.leave.pinf = 1'b0;
        res.leave.ninf = 1'b0;
        if (dv == '0) begin
            res.entry.pinf = apart;
            res.entry.ninf = !apart;
            res.leave.pinf = !apart;
            res.leave.ninf = apart;
            res.entry.num  = '0;
            res.leave.num  = '0;
            res.entry.den  = DEN_W'(1);
            res.leave.den  = DEN_W'(1);
        end else if (dv > 0) begin
            res.entry.num = tlo_e - mhi_e;
            res.leave.num = thi_e - mlo_e;
            res.entry.den = DEN_W'(dv);
            res.leave.den = DEN_W'(dv);
        end else begin
            // Negative motion: mirror the gaps so the denominator is positive.
            res.entry.num = mlo_e - thi_e;
            res.leave.num = mhi_e - tlo_e;
            res.entry.den = DEN_W'(-dv);
            res.leave.den = DEN_W'(-dv);
        end
        return res;
    endfunction

    function automatic logic is_negative(input span_time_t t);
        return t.ninf || (!t.pinf && t.num < 0);
    endfunction

    function automatic logic above_one(input span_time_t t);
        logic signed [GAP_W+SHIFT_FRAC_BITS:0] scaled;
        logic signed [GAP_W+SHIFT_FRAC_BITS:0] dsx;
        scaled = (GAP_W + SHIFT_FRAC_BITS + 1)'(t.num) <<< SHIFT_FRAC_BITS;
        dsx    = $signed((GAP_W + SHIFT_FRAC_BITS + 1)'({1'b0, t.den}));
        return t.pinf || (!t.ninf && scaled > dsx);
    endfunction

endpackage

`default_nettype wire

### rtl/core/swept_box_collision_time_unit.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time_unit
// Swept axis-aligned box test: entry time and contact normal of a moving box
// against a static box over one frame.
// ----------------------------------------------------------------------------
// The unit accepts one box pair per clock cycle while the result side is not
// stalled and returns one result per pair, in order. From an accepted input
// transaction to a valid result, five stages compute the per-axis times and
// the exact cross-multiplied comparisons, seventeen stages run a restoring
// divider one quotient bit each, and one output register holds the result. A
// stall on the result side holds the whole pipeline; no transaction is lost.
`default_nettype none

module swept_box_collision_time_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_mover_left,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_mover_top,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_mover_right,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_mover_bottom,
    input  wire logic signed [sbct_pkg::SHIFT_BITS-1:0] s_shift_x,
    input  wire logic signed [sbct_pkg::SHIFT_BITS-1:0] s_shift_y,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_target_left,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_target_top,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_target_right,
    input  wire logic signed [sbct_pkg::COORD_BITS-1:0] s_target_bottom,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_hit,
    output logic [sbct_pkg::TIME_W-1:0]               m_hit_time,
    output logic [1:0]                                m_normal_code
);

    localparam int NSTEP = sbct_pkg::DIV_STEPS;
    localparam int DW    = sbct_pkg::DEN_W;
    localparam int TW    = sbct_pkg::TIME_W;

    logic adv;

    // The whole pipeline moves when the output register is free or drained.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Stage 1: per-axis entry and exit times.
    logic                  v1_reg;
    sbct_pkg::axis_times_t ax1_reg, ay1_reg;
    logic                  xpos1_reg, ypos1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
        if (adv) begin
            ax1_reg   <= sbct_pkg::axis_times(s_mover_left, s_mover_right, s_target_left,
                                              s_target_right, s_shift_x);
            ay1_reg   <= sbct_pkg::axis_times(s_mover_top, s_mover_bottom, s_target_top,
                                              s_target_bottom, s_shift_y);
            xpos1_reg <= s_shift_x > 0;
            ypos1_reg <= s_shift_y > 0;
        end
    end

    // Stage 2: cross products for the entry and exit comparisons, early flags.
    logic                  v2_reg;
    sbct_pkg::axis_times_t ax2_reg, ay2_reg;
    logic                  xpos2_reg, ypos2_reg;
    logic signed [sbct_pkg::PROD_W-1:0] pel2_reg, per2_reg, pxl2_reg, pxr2_reg;
    logic                  early2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            xpos2_reg  <= xpos1_reg;
            ypos2_reg  <= ypos1_reg;
            pel2_reg   <= sbct_pkg::cross_prod(ax1_reg.entry.num, ay1_reg.entry.den);
            per2_reg   <= sbct_pkg::cross_prod(ay1_reg.entry.num, ax1_reg.entry.den);
            pxl2_reg   <= sbct_pkg::cross_prod(ax1_reg.leave.num, ay1_reg.leave.den);
            pxr2_reg   <= sbct_pkg::cross_prod(ay1_reg.leave.num, ax1_reg.leave.den);
            early2_reg <= (sbct_pkg::is_negative(ax1_reg.entry) &&
                           sbct_pkg::is_negative(ay1_reg.entry)) ||
                          sbct_pkg::above_one(ax1_reg.entry) ||
                          sbct_pkg::above_one(ay1_reg.entry);
        end
    end

    // Stage 3: pick the later entry, the earlier exit and the normal.
    logic signed [1:0]    ce2, cx2;
    logic [1:0]           nrm2;
    logic                 v3_reg;
    sbct_pkg::span_time_t ent3_reg, ext3_reg;
    logic                 early3_reg;
    logic [1:0]           nrm3_reg;

    always_comb begin
        ce2 = sbct_pkg::cmp_time(ax2_reg.entry, ay2_reg.entry, pel2_reg, per2_reg);
        cx2 = sbct_pkg::cmp_time(ax2_reg.leave, ay2_reg.leave, pxl2_reg, pxr2_reg);
        if (ce2 > 0) begin
            nrm2 = xpos2_reg ? sbct_pkg::NORMAL_LEFT : sbct_pkg::NORMAL_RIGHT;
        end else begin
            nrm2 = ypos2_reg ? sbct_pkg::NORMAL_UP : sbct_pkg::NORMAL_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            ent3_reg   <= (ce2 >= 0) ? ax2_reg.entry : ay2_reg.entry;
            ext3_reg   <= (cx2 <= 0) ? ax2_reg.leave : ay2_reg.leave;
            early3_reg <= early2_reg;
            nrm3_reg   <= nrm2;
        end
    end

    // Stage 4: cross products for entry against exit.
    logic                 v4_reg;
    sbct_pkg::span_time_t ent4_reg, ext4_reg;
    logic                 early4_reg;
    logic [1:0]           nrm4_reg;
    logic signed [sbct_pkg::PROD_W-1:0] pl4_reg, pr4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
        if (adv) begin
            ent4_reg   <= ent3_reg;
            ext4_reg   <= ext3_reg;
            early4_reg <= early3_reg;
            nrm4_reg   <= nrm3_reg;
            pl4_reg    <= sbct_pkg::cross_prod(ent3_reg.num, ext3_reg.den);
            pr4_reg    <= sbct_pkg::cross_prod(ext3_reg.num, ent3_reg.den);
        end
    end

    // Stage 5: hit decision and divider seed.
    // With a hit, num * 2^SHIFT_FRAC_BITS <= den, so the seed stays below den.
    logic signed [1:0] cee4;
    logic              hit4;

    assign cee4 = sbct_pkg::cmp_time(ent4_reg, ext4_reg, pl4_reg, pr4_reg);
    assign hit4 = !(cee4 > 0) && !early4_reg && !ent4_reg.pinf && !ent4_reg.ninf;

    logic          dv_reg   [NSTEP+1];
    logic          dhit_reg [NSTEP+1];
    logic [1:0]    dnrm_reg [NSTEP+1];
    logic [DW-1:0] drem_reg [NSTEP+1];
    logic [DW-1:0] dden_reg [NSTEP+1];
    logic [TW-1:0] dq_reg   [NSTEP+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v4_reg;
        end
        if (adv) begin
            dhit_reg[0] <= hit4;
            dnrm_reg[0] <= nrm4_reg;
            drem_reg[0] <= DW'(ent4_reg.num) << (sbct_pkg::SHIFT_FRAC_BITS - 1);
            dden_reg[0] <= ent4_reg.den;
            dq_reg[0]   <= '0;
        end
    end

    // Restoring divider: one quotient bit per stage.
    for (genvar i = 0; i < NSTEP; i++) begin : g_div
        logic [DW:0] dbl;
        logic        take;

        assign dbl  = {drem_reg[i], 1'b0};
        assign take = dbl >= {1'b0, dden_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[i+1] <= dv_reg[i];
            end
            if (adv) begin
                dhit_reg[i+1] <= dhit_reg[i];
                dnrm_reg[i+1] <= dnrm_reg[i];
                dden_reg[i+1] <= dden_reg[i];
                drem_reg[i+1] <= take ? DW'(dbl - {1'b0, dden_reg[i]}) : dbl[DW-1:0];
                dq_reg[i+1]   <= {dq_reg[i][TW-2:0], take};
            end
        end
    end

    // Output register.
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [TW-1:0] out_time_reg;
    logic [1:0]    out_nrm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_reg[NSTEP];
        end
        if (adv) begin
            out_hit_reg  <= dhit_reg[NSTEP];
            out_time_reg <= dhit_reg[NSTEP] ? dq_reg[NSTEP] : sbct_pkg::TIME_ONE;
            out_nrm_reg  <= dhit_reg[NSTEP] ? dnrm_reg[NSTEP] : sbct_pkg::NORMAL_LEFT;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hit         = out_hit_reg;
    assign m_hit_time    = out_time_reg;
    assign m_normal_code = out_nrm_reg;

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Swept box collision time unit testbench
// Drives box pairs through the valid/ready input channel and checks every
// result against a predictor that computes exact per-axis entry and exit
// times. Directed corner cases come first, then random phases with varying
// idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] ml, mt, mr, mb, vx, vy, tl, tt, tr, tb;
    } box_pair_t;

    typedef struct {
        logic        hit;
        logic [16:0] hit_time;
        logic [1:0]  normal;
    } contact_t;

    // Exact time: num * 256 / den, or an infinity (kind -1 / +1).
    typedef struct {
        int     kind;
        longint num;
        longint den;
    } frac_time_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_mover_left = '0, s_mover_top = '0;
    logic signed [15:0] s_mover_right = '0, s_mover_bottom = '0;
    logic signed [15:0] s_shift_x = '0, s_shift_y = '0;
    logic signed [15:0] s_target_left = '0, s_target_top = '0;
    logic signed [15:0] s_target_right = '0, s_target_bottom = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [sbct_pkg::TIME_W-1:0] m_hit_time;
    logic [1:0] m_normal_code;

    box_pair_t pending_pairs[$];
    contact_t  expected_contacts[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;

    swept_box_collision_time_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mover_left(s_mover_left), .s_mover_top(s_mover_top),
        .s_mover_right(s_mover_right), .s_mover_bottom(s_mover_bottom),
        .s_shift_x(s_shift_x), .s_shift_y(s_shift_y),
        .s_target_left(s_target_left), .s_target_top(s_target_top),
        .s_target_right(s_target_right), .s_target_bottom(s_target_bottom),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_hit_time(m_hit_time), .m_normal_code(m_normal_code)
    );

    // Clock and reset.
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Three-way compare of two exact times.
    function automatic int time_order(frac_time_t a, frac_time_t b);
        longint l, r;
        if (a.kind != 0 || b.kind != 0) begin
            return (a.kind == b.kind) ? 0 : ((a.kind < b.kind) ? -1 : 1);
        end
        l = a.num * b.den;
        r = b.num * a.den;
        return (l < r) ? -1 : ((l > r) ? 1 : 0);
    endfunction

    function automatic bit before_zero(frac_time_t t);
        return t.kind < 0 || (t.kind == 0 && t.num < 0);
    endfunction

    function automatic bit past_one(frac_time_t t);
        return t.kind > 0 || (t.kind == 0 && t.num * 256 > t.den);
    endfunction

    // Entry and exit times along one axis.
    function automatic void axis_span(longint lo, longint hi, longint olo, longint ohi,
                                      longint d, output frac_time_t t_in,
                                      output frac_time_t t_out);
        bit apart;
        t_in = '{0, 0, 1};
        t_out = '{0, 0, 1};
        if (d == 0) begin
            apart = (hi <= olo) || (lo >= ohi);
            t_in.kind = apart ? 1 : -1;
            t_out.kind = apart ? -1 : 1;
        end else if (d > 0) begin
            t_in = '{0, olo - hi, d};
            t_out = '{0, ohi - lo, d};
        end else begin
            t_in = '{0, lo - ohi, -d};
            t_out = '{0, hi - olo, -d};
        end
    endfunction

    function automatic contact_t predict_contact(box_pair_t p);
        frac_time_t xe, xx, ye, yx, ent, ext;
        contact_t c;
        axis_span(p.ml, p.mr, p.tl, p.tr, p.vx, xe, xx);
        axis_span(p.mt, p.mb, p.tt, p.tb, p.vy, ye, yx);
        ent = (time_order(xe, ye) >= 0) ? xe : ye;
        ext = (time_order(xx, yx) <= 0) ? xx : yx;
        if (time_order(ent, ext) > 0 || (before_zero(xe) && before_zero(ye)) ||
            past_one(xe) || past_one(ye)) begin
            c.hit = 1'b0;
            c.hit_time = 17'h10000;
            c.normal = sbct_pkg::NORMAL_LEFT;
            return c;
        end
        c.hit = 1'b1;
        if (ent.kind == 0 && ent.num >= 0)
            c.hit_time = 17'((ent.num <<< 24) / ent.den);
        else
            c.hit_time = '0;
        if (time_order(xe, ye) > 0)
            c.normal = (p.vx > 0) ? sbct_pkg::NORMAL_LEFT : sbct_pkg::NORMAL_RIGHT;
        else
            c.normal = (p.vy > 0) ? sbct_pkg::NORMAL_UP : sbct_pkg::NORMAL_DOWN;
        return c;
    endfunction

    function automatic box_pair_t make_pair(int ml, int mt, int mr, int mb, int vx, int vy,
                                            int tl, int tt, int tr, int tb);
        box_pair_t p;
        p = '{16'(ml), 16'(mt), 16'(mr), 16'(mb), 16'(vx), 16'(vy),
              16'(tl), 16'(tt), 16'(tr), 16'(tb)};
        return p;
    endfunction

    // Appends one pair to the queue of pending input transactions.
    function automatic void add_pair(box_pair_t p);
        pending_pairs = {pending_pairs, p};
    endfunction

    // Mostly near-miss and near-hit geometry, with some fully random pairs.
    function automatic box_pair_t random_pair();
        box_pair_t p;
        int cx, cy, w, h;
        if ($urandom_range(99) < 25) begin
            p = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom)};
            return p;
        end
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        w = $urandom_range(40);
        h = $urandom_range(40);
        p.tl = 16'(cx);
        p.tt = 16'(cy);
        p.tr = 16'(cx + w);
        p.tb = 16'(cy + h);
        cx = cx + int'($urandom_range(160)) - 80;
        cy = cy + int'($urandom_range(160)) - 80;
        p.ml = 16'(cx);
        p.mt = 16'(cy);
        p.mr = 16'(cx + int'($urandom_range(40)));
        p.mb = 16'(cy + int'($urandom_range(40)));
        p.vx = ($urandom_range(9) == 0) ? 16'sd0 : 16'(int'($urandom_range(60000)) - 30000);
        p.vy = ($urandom_range(9) == 0) ? 16'sd0 : 16'(int'($urandom_range(60000)) - 30000);
        if ($urandom_range(9) == 0) begin
            p.vx = 16'(int'($urandom_range(512)) - 256);
        end
        return p;
    endfunction

    // Driver: predicts each accepted transaction and presents the next pair.
    always @(posedge aclk) begin
        logic present;
        box_pair_t p;
        box_pair_t seen;
        present = s_valid;
        if (!aresetn) begin
            present = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen = '{s_mover_left, s_mover_top, s_mover_right, s_mover_bottom,
                         s_shift_x, s_shift_y, s_target_left, s_target_top,
                         s_target_right, s_target_bottom};
                expected_contacts = {expected_contacts, predict_contact(seen)};
                present = 1'b0;
            end
            if (!present && pending_pairs.size() > 0 &&
                $urandom_range(99) >= idle_pct) begin
                p = pending_pairs.pop_front();
                present = 1'b1;
                s_mover_left <= p.ml;
                s_mover_top <= p.mt;
                s_mover_right <= p.mr;
                s_mover_bottom <= p.mb;
                s_shift_x <= p.vx;
                s_shift_y <= p.vy;
                s_target_left <= p.tl;
                s_target_top <= p.tt;
                s_target_right <= p.tr;
                s_target_bottom <= p.tb;
            end
        end
        s_valid <= present;
    end

    // Monitor: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        contact_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_contacts.size() == 0) begin
                $error("result transaction with no expectation pending");
                errors++;
            end else begin
                e = expected_contacts.pop_front();
                if (m_hit !== e.hit) begin
                    $error("hit: expected %0d, actual %0d", e.hit, m_hit);
                    errors++;
                end
                if (m_hit_time !== e.hit_time) begin
                    $error("hit_time: expected %0d, actual %0d", e.hit_time, m_hit_time);
                    errors++;
                end
                if (m_normal_code !== e.normal) begin
                    $error("normal_code: expected %0d, actual %0d", e.normal, m_normal_code);
                    errors++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    task automatic drain_all();
        while (pending_pairs.size() > 0 || s_valid || expected_contacts.size() > 0)
            @(posedge aclk);
    endtask

    // Stimulus sequence.
    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set = '{0, 54, 0, 23};
        stall_set = '{0, 0, 54, 23};
        @(posedge aclk iff aresetn);

        // Extremes of every field.
        add_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768, -32768));
        add_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 32767));
        add_pair(make_pair(-32768, -32768, 32767, 32767, 32767, -32768,
                           32767, 32767, -32768, -32768));
        add_pair(make_pair(-32768, 0, -32760, 8, 32767, 0, 32760, 0, 32767, 8));
        // Zero displacement on both axes: overlapping, apart, and touching edges.
        add_pair(make_pair(0, 0, 10, 10, 0, 0, 5, 5, 15, 15));
        add_pair(make_pair(0, 0, 10, 10, 0, 0, 20, 0, 30, 10));
        add_pair(make_pair(0, 0, 10, 10, 0, 0, 10, 0, 20, 10));
        // Hits from each side.
        add_pair(make_pair(0, 0, 10, 10, 2560, 0, 15, 0, 25, 10));
        add_pair(make_pair(30, 0, 40, 10, -2560, 0, 15, 0, 25, 10));
        add_pair(make_pair(0, 0, 10, 10, 0, 2560, 0, 15, 10, 25));
        add_pair(make_pair(0, 30, 10, 40, 0, -2560, 0, 15, 10, 25));
        // Entry at exactly one, just past one, and exactly zero.
        add_pair(make_pair(0, 0, 10, 10, 1280, 0, 15, 0, 25, 10));
        add_pair(make_pair(0, 0, 10, 10, 1279, 0, 15, 0, 25, 10));
        add_pair(make_pair(0, 0, 10, 10, 256, 0, 10, 0, 20, 10));
        // Equal entry times on both axes go to the vertical normal.
        add_pair(make_pair(0, 0, 10, 10, 2560, 2560, 15, 15, 25, 25));
        // Both entries negative, and entry after exit.
        add_pair(make_pair(20, 20, 30, 30, 256, 256, 0, 0, 10, 10));
        add_pair(make_pair(0, 0, 10, 10, 2560, 256, 15, 50, 25, 60));
        // Inverted boxes.
        add_pair(make_pair(10, 10, 0, 0, 512, -512, 5, 15, 15, 5));
        add_pair(make_pair(0, 0, 10, 10, -300, 700, 20, 20, -5, -5));
        // Tiny displacement and odd quotient.
        add_pair(make_pair(0, 0, 3, 3, 1, 0, 3, 0, 6, 3));
        add_pair(make_pair(0, 0, 7, 7, 2303, -1, 8, 0, 12, 7));
        drain_all();

        // Random phases; each waits for all results before idling changes.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int i = 0; i < 235; i++)
                add_pair(random_pair());
            drain_all();
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_contacts.size() == 0) begin
            $display("PASS swept_box_collision_time_unit");
        end else begin
            $display("FAIL swept_box_collision_time_unit");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("FAIL swept_box_collision_time_unit");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/core/sbct_pkg.sv
rtl/core/swept_box_collision_time_unit.sv
sim/testbench.sv
